>>> hw/rtl/adsr_pkg.sv
// ----------------------------------------------------------------------------
// ADSR setup package
// Shared constants, codes and defaults for the envelope segment setup block.
// ----------------------------------------------------------------------------
package adsr_pkg;

  localparam int TIME_BITS_DEF       = 16;
  localparam int LEVEL_BITS_DEF      = 16;
  localparam int SLOPE_FRAC_BITS_DEF = 16;

  // Slope magnitudes are carried as 32-bit Q16.16 values; signed slopes add a sign bit.
  localparam int MAG_W   = 32;
  localparam int SLOPE_W = MAG_W + 1;
  localparam int STAT_W  = 2;
  localparam int CFG_AW  = 2;

  typedef enum logic [STAT_W-1:0] {
    ST_OK           = 2'd0,
    ST_RELEASE_LONG = 2'd1,
    ST_PEAK_LOW     = 2'd2
  } status_t;

  typedef enum logic [CFG_AW-1:0] {
    REG_ATTACK  = 2'd0,
    REG_DECAY   = 2'd1,
    REG_RELEASE = 2'd2,
    REG_SUSTAIN = 2'd3
  } cfg_reg_t;

endpackage

>>> hw/rtl/adsr_envelope_segment_setup_core.sv
// ----------------------------------------------------------------------------
// ADSR envelope segment setup core
// Fits the configured attack, decay, release and sustain settings to each
// note and produces segment end times, slopes and the held sustain level.
// ----------------------------------------------------------------------------
// One beat in gives one result beat out. The block is a pipeline of
// LEVEL_BITS + SLOPE_FRAC_BITS + 2 stages (34 with the defaults): one setup
// stage that picks the fitting case and the three segment lengths, one
// stage per quotient bit in each of three parallel restoring dividers, and
// an output stage that saturates and negates the falling slopes. A new
// beat is taken in every cycle unless a result-side stall has filled every
// stage. Stalls on the result side fill empty stages first, so the input
// keeps accepting while any stage holds a bubble. Zero-length segments get a
// zero slope, and a release that fills the whole note makes the note pure
// release from the peak. Configuration goes in through cfg_we, cfg_addr
// and cfg_wdata; the user must write it only while no note is in flight,
// as the block does not enforce this. All four indexes select a register.
module adsr_envelope_segment_setup_core #(
  parameter int TIME_BITS       = adsr_pkg::TIME_BITS_DEF,
  parameter int LEVEL_BITS      = adsr_pkg::LEVEL_BITS_DEF,
  parameter int SLOPE_FRAC_BITS = adsr_pkg::SLOPE_FRAC_BITS_DEF,
  localparam int IN_W  = ((TIME_BITS + LEVEL_BITS + 7) / 8) * 8,
  localparam int OUT_RAW = adsr_pkg::STAT_W + 3 * TIME_BITS + adsr_pkg::MAG_W
                           + 2 * adsr_pkg::SLOPE_W + LEVEL_BITS,
  localparam int OUT_W = ((OUT_RAW + 7) / 8) * 8,
  localparam int CFG_W = (TIME_BITS > LEVEL_BITS) ? TIME_BITS : LEVEL_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [adsr_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [CFG_W-1:0]          cfg_wdata,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // in_tdata, from bit 0 up: note_duration, peak_level, zero fill.
  input  logic [IN_W-1:0]           in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // out_tdata, from bit 0 up: status, attack_end, decay_end, sustain_end,
  // attack_slope, decay_slope, release_slope, sustain_out, zero fill.
  output logic [OUT_W-1:0]          out_tdata
);

  import adsr_pkg::*;

  localparam int NB = LEVEL_BITS + SLOPE_FRAC_BITS;
  localparam int S  = NB + 2;

  // Configuration registers.
  logic [TIME_BITS-1:0]  attack_r, decay_r, release_r;
  logic [LEVEL_BITS-1:0] sustain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r  <= TIME_BITS'(1);
      decay_r   <= TIME_BITS'(1);
      release_r <= TIME_BITS'(1);
      sustain_r <= LEVEL_BITS'(1) << (LEVEL_BITS - 1);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_ATTACK:  attack_r  <= cfg_wdata[TIME_BITS-1:0];
        REG_DECAY:   decay_r   <= cfg_wdata[TIME_BITS-1:0];
        REG_RELEASE: release_r <= cfg_wdata[TIME_BITS-1:0];
        REG_SUSTAIN: sustain_r <= cfg_wdata[LEVEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Flow control. A stage may load when it or any later stage is empty or the
  // result is being taken, so bubbles close up under a stall.
  logic [S-1:0] valid_r;
  logic [S-1:0] rdy;

  always_comb begin
    for (int k = 0; k < S; k++) begin
      rdy[k] = out_tready || !(&(valid_r | ((S'(1) << k) - S'(1))));
    end
  end

  assign in_tready  = rdy[0];
  assign out_tvalid = valid_r[S-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (rdy[0]) begin
        valid_r[0] <= in_tvalid;
      end
      for (int k = 1; k < S; k++) begin
        if (rdy[k]) begin
          valid_r[k] <= valid_r[k-1];
        end
      end
    end
  end

  // Setup stage: choose the fitting case.
  logic [TIME_BITS-1:0]  dur, a_len_nxt, d_len_nxt, r_len_nxt, rest;
  logic [LEVEL_BITS-1:0] peak, a_num_nxt, d_num_nxt, r_num_nxt, s_out_nxt;
  logic [TIME_BITS+1:0]  sum_adr, sum_ar;
  logic [TIME_BITS-1:0]  a_end_nxt, d_end_nxt, s_end_nxt;
  status_t               stat_nxt;

  assign dur  = in_tdata[TIME_BITS-1:0];
  assign peak = in_tdata[TIME_BITS +: LEVEL_BITS];
  assign rest = dur - release_r;
  assign sum_adr = {2'b00, attack_r} + {2'b00, decay_r} + {2'b00, release_r};
  assign sum_ar  = {2'b00, attack_r} + {2'b00, release_r};

  always_comb begin
    stat_nxt  = ST_OK;
    a_end_nxt = '0;
    d_end_nxt = '0;
    s_end_nxt = '0;
    s_out_nxt = '0;
    a_num_nxt = '0;
    d_num_nxt = '0;
    r_num_nxt = '0;
    a_len_nxt = '0;
    d_len_nxt = '0;
    r_len_nxt = '0;
    if (release_r > dur) begin
      stat_nxt = ST_RELEASE_LONG;
    end else if (peak <= sustain_r) begin
      stat_nxt = ST_PEAK_LOW;
    end else if (sum_ar >= {2'b00, dur}) begin
      // Attack cut to what release leaves; this also covers a note that
      // is all release, where that length is zero.
      a_end_nxt = rest;
      d_end_nxt = rest;
      s_end_nxt = rest;
      s_out_nxt = peak;
      a_num_nxt = peak;
      a_len_nxt = rest;
      r_num_nxt = peak;
      r_len_nxt = release_r;
    end else begin
      a_end_nxt = attack_r;
      s_out_nxt = sustain_r;
      a_num_nxt = peak;
      a_len_nxt = attack_r;
      d_num_nxt = peak - sustain_r;
      r_num_nxt = sustain_r;
      r_len_nxt = release_r;
      s_end_nxt = rest;
      if (sum_adr >= {2'b00, dur}) begin
        d_end_nxt = rest;
        d_len_nxt = rest - attack_r;
      end else begin
        d_end_nxt = attack_r + decay_r;
        d_len_nxt = decay_r;
      end
    end
  end

  // Divider operands: a zero length becomes 0 / 1 so the slope is zero.
  logic [LEVEL_BITS-1:0] a_num_r, d_num_r, r_num_r;
  logic [TIME_BITS-1:0]  a_den_r, d_den_r, r_den_r;

  // Fields that ride alongside the dividers.
  logic [STAT_W-1:0]     stat_r  [S];
  logic [TIME_BITS-1:0]  a_end_r [S];
  logic [TIME_BITS-1:0]  d_end_r [S];
  logic [TIME_BITS-1:0]  s_end_r [S];
  logic [LEVEL_BITS-1:0] s_out_r [S];

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      a_num_r <= (a_len_nxt == '0) ? '0 : a_num_nxt;
      d_num_r <= (d_len_nxt == '0) ? '0 : d_num_nxt;
      r_num_r <= (r_len_nxt == '0) ? '0 : r_num_nxt;
      a_den_r <= (a_len_nxt == '0) ? TIME_BITS'(1) : a_len_nxt;
      d_den_r <= (d_len_nxt == '0) ? TIME_BITS'(1) : d_len_nxt;
      r_den_r <= (r_len_nxt == '0) ? TIME_BITS'(1) : r_len_nxt;
      stat_r[0]  <= stat_nxt;
      a_end_r[0] <= a_end_nxt;
      d_end_r[0] <= d_end_nxt;
      s_end_r[0] <= s_end_nxt;
      s_out_r[0] <= s_out_nxt;
    end
    for (int k = 1; k < S; k++) begin
      if (rdy[k]) begin
        stat_r[k]  <= stat_r[k-1];
        a_end_r[k] <= a_end_r[k-1];
        d_end_r[k] <= d_end_r[k-1];
        s_end_r[k] <= s_end_r[k-1];
        s_out_r[k] <= s_out_r[k-1];
      end
    end
  end

  // Three parallel dividers occupy stages 1 to NB.
  logic [NB-1:0] a_quo, d_quo, r_quo;

  adsr_div #(.NUM_W(LEVEL_BITS), .FRAC_BITS(SLOPE_FRAC_BITS), .DEN_W(TIME_BITS))
    u_div_attack (.clk(clk), .en(rdy[NB:1]), .num_i(a_num_r), .den_i(a_den_r),
                  .quo_o(a_quo));
  adsr_div #(.NUM_W(LEVEL_BITS), .FRAC_BITS(SLOPE_FRAC_BITS), .DEN_W(TIME_BITS))
    u_div_decay (.clk(clk), .en(rdy[NB:1]), .num_i(d_num_r), .den_i(d_den_r),
                 .quo_o(d_quo));
  adsr_div #(.NUM_W(LEVEL_BITS), .FRAC_BITS(SLOPE_FRAC_BITS), .DEN_W(TIME_BITS))
    u_div_release (.clk(clk), .en(rdy[NB:1]), .num_i(r_num_r), .den_i(r_den_r),
                   .quo_o(r_quo));

  // Output stage: saturate each magnitude to 32 bits, negate falling slopes.
  logic [MAG_W-1:0] a_mag, d_mag, r_mag;

  if (NB > MAG_W) begin : g_sat
    assign a_mag = (|a_quo[NB-1:MAG_W]) ? '1 : a_quo[MAG_W-1:0];
    assign d_mag = (|d_quo[NB-1:MAG_W]) ? '1 : d_quo[MAG_W-1:0];
    assign r_mag = (|r_quo[NB-1:MAG_W]) ? '1 : r_quo[MAG_W-1:0];
  end else begin : g_nosat
    assign a_mag = MAG_W'(a_quo);
    assign d_mag = MAG_W'(d_quo);
    assign r_mag = MAG_W'(r_quo);
  end

  logic [MAG_W-1:0]   a_slope_r;
  logic [SLOPE_W-1:0] d_slope_r, r_slope_r;

  always_ff @(posedge clk) begin
    if (rdy[S-1]) begin
      a_slope_r <= a_mag;
      d_slope_r <= SLOPE_W'(0) - {1'b0, d_mag};
      r_slope_r <= SLOPE_W'(0) - {1'b0, r_mag};
    end
  end

  assign out_tdata = OUT_W'({s_out_r[S-1], r_slope_r, d_slope_r, a_slope_r,
                             s_end_r[S-1], d_end_r[S-1], a_end_r[S-1],
                             stat_r[S-1]});

endmodule

>>> hw/rtl/adsr_div.sv
// ----------------------------------------------------------------------------
// ADSR pipelined divider
// Restoring divider computing floor((num << FRAC_BITS) / den), one quotient
// bit per register stage. Each stage loads when its enable bit is high.
// ----------------------------------------------------------------------------
module adsr_div #(
  parameter int NUM_W     = 16,
  parameter int FRAC_BITS = 16,
  parameter int DEN_W     = 16,
  localparam int NB       = NUM_W + FRAC_BITS
) (
  input  logic             clk,
  input  logic [NB-1:0]    en,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [NB-1:0]    quo_o
);

  logic [DEN_W-1:0] rem_r [NB];
  logic [NB-1:0]    num_r [NB];
  logic [NB-1:0]    quo_r [NB];
  logic [DEN_W-1:0] den_r [NB];

  for (genvar k = 0; k < NB; k++) begin : g_stage
    logic [DEN_W-1:0] rem_p;
    logic [NB-1:0]    num_p;
    logic [NB-1:0]    quo_p;
    logic [DEN_W-1:0] den_p;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_p = '0;
      assign num_p = {num_i, {FRAC_BITS{1'b0}}};
      assign quo_p = '0;
      assign den_p = den_i;
    end else begin : g_next
      assign rem_p = rem_r[k-1];
      assign num_p = num_r[k-1];
      assign quo_p = quo_r[k-1];
      assign den_p = den_r[k-1];
    end

    assign trial = {rem_p, num_p[NB-1]};
    assign diff  = trial - {1'b0, den_p};
    assign ge    = (trial >= {1'b0, den_p});

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem_r[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        num_r[k] <= {num_p[NB-2:0], 1'b0};
        quo_r[k] <= {quo_p[NB-2:0], ge};
        den_r[k] <= den_p;
      end
    end
  end

  assign quo_o = quo_r[NB-1];

endmodule

>>> hw/rtl/adsr_checker.sv
// ----------------------------------------------------------------------------
// ADSR setup port checker
// Watches the result port of the setup core and is bound to it.
// ----------------------------------------------------------------------------
module adsr_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [167:0] out_tdata
);

  // A failed fit carries nothing but its status.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[1:0] != 2'd0) |-> out_tdata[163:2] == '0)
    else $error("failed fit carries nonzero fields");

  // Status code three is never produced.
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'd3)
    else $error("illegal status code");

  // The decay slope is zero or negative.
  a_decay_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[114:82] != '0) |-> out_tdata[114])
    else $error("decay slope positive");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

endmodule

bind adsr_envelope_segment_setup_core adsr_checker u_adsr_checker (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata)
);
